// ===== hw/rtl/ppts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppts_pkg
// Shared codes, event and result beat layouts for the task scheduler.
// ----------------------------------------------------------------------------
package ppts_pkg;

    localparam logic [1:0] KIND_TICK   = 2'd0;
    localparam logic [1:0] KIND_CREATE = 2'd1;
    localparam logic [1:0] KIND_SLEEP  = 2'd2;
    localparam logic [1:0] KIND_DELETE = 2'd3;

    localparam logic [1:0] ST_READY    = 2'd0;
    localparam logic [1:0] ST_RUNNING  = 2'd1;
    localparam logic [1:0] ST_SLEEPING = 2'd2;
    localparam logic [1:0] ST_REMOVED  = 2'd3;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_OCCUPIED = 2'd1;
    localparam logic [1:0] ERR_NO_RUN   = 2'd2;

    localparam logic [14:0] ID_MAX = 15'h7FFF;

    localparam int PRIO_W  = 8;
    localparam int STAMP_W = 16;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  task_slot;
        logic [7:0]  priority_req;
        logic        privileged;
        logic [31:0] delay_ticks;
        logic        sleep_forever;
        logic        slice_end;
    } t_item;

    typedef struct packed {
        logic [3:0]         run_slot;
        logic               run_valid;
        logic               switch_request;
        logic signed [15:0] new_task_id;
        logic [1:0]         error;
    } t_result;

endpackage

// ===== hw/rtl/ppts_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppts_item_if / ppts_result_if
// Valid/ready channels carrying one scheduler event or one scheduler result.
// ----------------------------------------------------------------------------
interface ppts_item_if import ppts_pkg::*; ();
    logic  valid;
    logic  ready;
    t_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ppts_result_if import ppts_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/priority_preemptive_task_scheduler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_preemptive_task_scheduler_core
// Event-driven task scheduler: ticks, create, sleep and delete events update a
// slot table held in RAM; every event yields one beat naming the task to run.
// ----------------------------------------------------------------------------
// Usage:
//   s_item   : event beats (kind, slot, priority, delay, flags). One at a time.
//   m_result : one result beat per event (run slot, switch request, id, error).
//   APB      : register 0 at byte address 0 holds scheduling_enabled; write it
//              only while the block is idle.
// Sequencing:
//   A sequencer walks the slot RAM, one slot read per cycle. A rejected create,
//   a create with scheduling disabled and a sleep or delete with no running
//   task skip the scans and go straight to the result state. Any other event
//   runs one selection scan, plus a successor scan when a time slice is pending
//   and the running task stays ready, then commit and result. A tick first runs
//   the wake sweep, one scan per woken task plus a last scan finding nothing.
//   The slot RAM has a single read port.
// Reset: the slot-used bits, running task, tick count and stamp counter clear
//   at once and the id counter restarts at 1; the slot RAM is left as is and a
//   slot is always written on create before its contents are used.
// Stall: the result waits in an output register; the next event is accepted
//   in the cycle after that beat has been taken, at the earliest.
// ----------------------------------------------------------------------------
module priority_preemptive_task_scheduler_core
    import ppts_pkg::*;
#(
    parameter int TASK_SLOTS = 16,
    parameter int TICK_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ppts_item_if.sink   s_item,
    ppts_result_if.source m_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int SW = $clog2(TASK_SLOTS);
    localparam int CW = $clog2(TASK_SLOTS + 1);
    // slot record: priority, status, deadline, no-wake flag, stamp
    localparam int RW = PRIO_W + 2 + TICK_WIDTH + 1 + STAMP_W;
    localparam logic [TICK_WIDTH-1:0] TICK_MAX = '1;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WAKE   = 3'd1;
    localparam logic [2:0] S_PICK   = 3'd2;
    localparam logic [2:0] S_PICK2  = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    typedef struct packed {
        logic [PRIO_W-1:0]     prio;
        logic [1:0]            status;
        logic [TICK_WIDTH-1:0] deadline;
        logic                  no_wake;
        logic [STAMP_W-1:0]    stamp;
    } t_slot;

    // ---------------------------------------------------------------- APB
    logic r_sched_en;
    assign pready = 1'b1;
    assign prdata = {31'd0, r_sched_en};

    // ---------------------------------------------------------------- state
    logic [2:0]            r_state;
    logic [TASK_SLOTS-1:0] r_used;
    logic [SW-1:0]         r_run_slot;
    logic                  r_run_valid;
    logic                  r_preempt;
    logic [TICK_WIDTH-1:0] r_tick;
    logic [14:0]           r_next_id;
    logic [STAMP_W-1:0]    r_stamp_ctr;
    t_item                 r_item;
    t_result               r_res;
    logic                  r_res_valid;

    // scan bookkeeping
    logic [CW-1:0]         r_cnt;       // address being issued
    logic                  r_rd_vld;    // read data in flight
    logic [SW-1:0]         r_rd_addr;
    logic                  r_best_vld;
    logic [SW-1:0]         r_best;
    t_slot                 r_best_rec;
    t_slot                 r_run_rec;   // record of running slot (captured in scan)
    logic                  r_run_seen;
    logic                  r_sw;

    // RAM
    logic                  ram_we;
    logic [SW-1:0]         ram_waddr;
    t_slot                 ram_wdata;
    logic [SW-1:0]         ram_raddr;
    logic [RW-1:0]         ram_rdata;
    t_slot                 rd;

    ppts_ram #(.WIDTH(RW), .DEPTH(TASK_SLOTS)) u_slots (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );
    assign rd = t_slot'(ram_rdata);
    assign ram_raddr = r_cnt[SW-1:0];

    assign s_item.ready   = (r_state == S_IDLE) && !r_res_valid;
    assign m_result.valid = r_res_valid;
    assign m_result.data  = r_res;

    wire accept  = s_item.valid && s_item.ready;
    wire [SW-1:0] acc_slot = SW'(s_item.data.task_slot);
    wire scan_end = r_rd_vld && (r_rd_addr == SW'(TASK_SLOTS - 1));
    wire rd_used = r_used[r_rd_addr];
    wire rd_ready_set = rd_used && (rd.status == ST_READY || rd.status == ST_RUNNING);

    // wake candidate comparison
    wire wake_cand = rd_used && rd.status == ST_SLEEPING && !rd.no_wake &&
                     rd.deadline <= r_tick;
    wire wake_better = !r_best_vld || rd.deadline < r_best_rec.deadline ||
                       (rd.deadline == r_best_rec.deadline &&
                        rd.stamp > r_best_rec.stamp);
    // best ready comparison
    wire pick_better = !r_best_vld || rd.prio < r_best_rec.prio ||
                       (rd.prio == r_best_rec.prio && rd.stamp > r_best_rec.stamp);
    // time-slice successor comparison against running record
    wire succ_cand = rd_ready_set && r_rd_addr != r_run_slot &&
                     rd.prio == r_run_rec.prio && rd.stamp < r_run_rec.stamp;
    wire succ_better = !r_best_vld || rd.stamp > r_best_rec.stamp;

    wire run_is_rd = r_run_valid && r_rd_addr == r_run_slot;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_run_slot;
        ram_wdata = r_run_rec;
        if (accept && s_item.data.kind == KIND_CREATE &&
            !r_used[acc_slot] &&
            ({28'd0, s_item.data.task_slot} < 32'(TASK_SLOTS))) begin
            ram_we    = 1'b1;
            ram_waddr = acc_slot;
            ram_wdata = '{prio: s_item.data.priority_req, status: ST_READY,
                          deadline: '0, no_wake: 1'b0, stamp: r_stamp_ctr};
        end else if (accept && s_item.data.kind == KIND_SLEEP && r_run_valid &&
                     r_used[r_run_slot]) begin
            // the sleeping record is written during the scan, from the record read there
            ram_we = 1'b0;
        end else if (r_state == S_WAKE && scan_end && (r_best_vld ||
                     (wake_cand && wake_better))) begin
            ram_we    = 1'b1;
            ram_waddr = (wake_cand && wake_better) ? r_rd_addr : r_best;
            ram_wdata = (wake_cand && wake_better) ? rd : r_best_rec;
            ram_wdata.status   = ST_READY;
            ram_wdata.deadline = '0;
            ram_wdata.stamp    = r_stamp_ctr;
        end else if (r_state == S_COMMIT && r_best_vld) begin
            ram_we    = 1'b1;
            ram_waddr = r_best;
            ram_wdata = r_best_rec;
            ram_wdata.status = ST_RUNNING;
        end else if (r_state == S_DONE && r_sw && r_run_seen &&
                     r_run_rec.status == ST_RUNNING) begin
            // demote previous running task
            ram_we    = 1'b1;
            ram_waddr = r_rd_addr;
            ram_wdata = r_run_rec;
            ram_wdata.status = ST_READY;
        end else if (r_state == S_PICK && r_rd_vld && run_is_rd &&
                     r_item.kind == KIND_SLEEP && rd.status == ST_RUNNING &&
                     r_res.error == ERR_OK && !r_run_seen) begin
            // apply the sleep to the running record as it streams by
            ram_we    = 1'b1;
            ram_waddr = r_rd_addr;
            ram_wdata = rd;
            ram_wdata.status  = ST_SLEEPING;
            ram_wdata.no_wake = r_item.sleep_forever;
            ram_wdata.stamp   = r_stamp_ctr;
            if (r_item.sleep_forever ||
                {1'b0, r_item.delay_ticks} > {1'b0, TICK_MAX - r_tick})
                ram_wdata.deadline = TICK_MAX;
            else
                ram_wdata.deadline = r_tick + TICK_WIDTH'(r_item.delay_ticks);
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sched_en  <= 1'b0;
            r_used      <= '0;
            r_run_slot  <= '0;
            r_run_valid <= 1'b0;
            r_preempt   <= 1'b0;
            r_tick      <= '0;
            r_next_id   <= 15'd1;
            r_stamp_ctr <= '0;
            r_res_valid <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_cnt       <= '0;
            r_best_vld  <= 1'b0;
            r_run_seen  <= 1'b0;
            r_sw        <= 1'b0;
        end else begin
            if (psel && penable && pwrite && paddr == 2'd0)
                r_sched_en <= pwdata[0];
            if (m_result.valid && m_result.ready)
                r_res_valid <= 1'b0;

            // pipeline of the read port: address issued now returns next cycle
            r_rd_vld  <= (r_state != S_IDLE && r_state != S_COMMIT &&
                          r_state != S_DONE) && (r_cnt < CW'(TASK_SLOTS));
            r_rd_addr <= r_cnt[SW-1:0];
            if (r_state != S_IDLE && r_cnt < CW'(TASK_SLOTS))
                r_cnt <= r_cnt + 1'b1;

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_item      <= s_item.data;
                        r_cnt       <= '0;
                        r_best_vld  <= 1'b0;
                        r_run_seen  <= 1'b0;
                        r_res.new_task_id <= '0;
                        r_res.error <= ERR_OK;
                        case (s_item.data.kind)
                            KIND_TICK: begin
                                r_tick <= r_tick + 1'b1;
                                if (s_item.data.slice_end) r_preempt <= 1'b1;
                                r_state <= S_WAKE;
                            end
                            KIND_CREATE: begin
                                if ({28'd0, s_item.data.task_slot} >= 32'(TASK_SLOTS) ||
                                    r_used[acc_slot]) begin
                                    r_res.error <= ERR_OCCUPIED;
                                    r_sw    <= 1'b0;
                                    r_state <= S_DONE;
                                end else begin
                                    r_used[acc_slot] <= 1'b1;
                                    r_stamp_ctr <= r_stamp_ctr + 1'b1;
                                    r_res.new_task_id <= s_item.data.privileged ?
                                        -$signed({1'b0, r_next_id}) :
                                        $signed({1'b0, r_next_id});
                                    r_next_id <= (r_next_id >= ID_MAX) ? 15'd1 :
                                                 r_next_id + 1'b1;
                                    r_sw    <= 1'b0;
                                    r_state <= r_sched_en ? S_PICK : S_DONE;
                                end
                            end
                            default: begin
                                if (!r_run_valid || !r_used[r_run_slot]) begin
                                    r_res.error <= ERR_NO_RUN;
                                    r_sw    <= 1'b0;
                                    r_state <= S_DONE;
                                end else begin
                                    if (s_item.data.kind == KIND_DELETE)
                                        r_used[r_run_slot] <= 1'b0;
                                    r_state <= S_PICK;
                                end
                            end
                        endcase
                    end
                end
                S_WAKE: begin
                    if (r_rd_vld && wake_cand && wake_better) begin
                        r_best_vld <= 1'b1;
                        r_best     <= r_rd_addr;
                        r_best_rec <= rd;
                    end
                    if (scan_end) begin
                        r_cnt      <= '0;
                        r_best_vld <= 1'b0;
                        if (r_best_vld || (wake_cand && wake_better))
                            r_stamp_ctr <= r_stamp_ctr + 1'b1;
                        else
                            r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (r_rd_vld) begin
                        if (run_is_rd) begin
                            r_run_seen <= 1'b1;
                            r_run_rec  <= rd;
                            if (r_item.kind == KIND_SLEEP && r_res.error == ERR_OK &&
                                !r_run_seen) begin
                                r_run_rec.status <= ST_SLEEPING;
                                r_stamp_ctr <= r_stamp_ctr + 1'b1;
                            end
                        end
                        if (rd_ready_set && !(run_is_rd && (r_item.kind == KIND_SLEEP ||
                            r_item.kind == KIND_DELETE)) && pick_better) begin
                            r_best_vld <= 1'b1;
                            r_best     <= r_rd_addr;
                            r_best_rec <= rd;
                        end
                    end
                    if (scan_end) begin
                        r_cnt <= '0;
                        // time slice: look for a successor when the running task stays
                        if (r_preempt && r_run_valid && r_item.kind != KIND_SLEEP &&
                            r_item.kind != KIND_DELETE &&
                            (run_is_rd ? rd_ready_set :
                             (r_run_seen && r_used[r_run_slot] &&
                              (r_run_rec.status == ST_READY ||
                               r_run_rec.status == ST_RUNNING))))
                            r_state <= S_PICK2;
                        else
                            r_state <= S_COMMIT;
                    end
                end
                S_PICK2: begin
                    if (r_rd_vld && succ_cand && (r_state == S_PICK2) &&
                        (!r_run_seen || 1'b1)) begin
                        // reuse best slot: first successor hit replaces the pick
                        if (!r_sw || succ_better) begin
                            r_sw       <= 1'b1;
                            r_best     <= r_rd_addr;
                            r_best_rec <= rd;
                        end
                    end
                    if (scan_end) r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    // r_best_vld: any ready task found
                    r_rd_addr <= r_run_slot;
                    if (!r_best_vld) begin
                        r_sw <= r_run_valid;
                        if (r_run_valid) begin
                            r_run_valid <= 1'b0;
                            r_run_slot  <= '0;
                            r_preempt   <= 1'b0;
                        end
                    end else begin
                        r_sw <= !(r_run_valid && r_run_slot == r_best);
                        if (!(r_run_valid && r_run_slot == r_best)) begin
                            r_run_valid <= 1'b1;
                            r_run_slot  <= r_best;
                            r_preempt   <= 1'b0;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    r_res.run_slot       <= 4'(r_run_slot);
                    r_res.run_valid      <= r_run_valid;
                    r_res.switch_request <= r_sw;
                    r_res_valid          <= 1'b1;
                    r_sw                 <= 1'b0;
                    r_run_seen           <= 1'b0;
                    r_state              <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // ---------------------------------------------------------------- checks
    property p_one_item;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state != S_IDLE) |-> !s_item.ready;
    endproperty
    a_one_item: assert property (p_one_item) else $error("item accepted while busy");

    property p_result_after_done;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_DONE) |=> r_res_valid;
    endproperty
    a_result_after_done: assert property (p_result_after_done)
        else $error("result missing after event");

    property p_run_used;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_DONE && r_run_valid) |-> r_used[r_run_slot];
    endproperty
    a_run_used: assert property (p_run_used) else $error("running slot not in use");

endmodule

// ===== hw/rtl/ppts_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppts_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ppts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
